// ===== rtl/core/rss_pkg.sv =====
`timescale 1ns / 1ps

package rss_pkg;

	// Width of one repeat field in the stage_repeats register.
	localparam int unsigned REP_BITS = 3;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		CFG_STAGE_LEVELS  = 4'd0,
		CFG_STAGE_REPEATS = 4'd1,
		CFG_LEVEL_SCALE   = 4'd2,
		CFG_PULSE_TICKS   = 4'd3
	} cfg_index_t;

	// Reset values of the configuration registers.
	localparam logic [63:0] STAGE_LEVELS_RESET  = 64'd0;
	localparam logic [23:0] STAGE_REPEATS_RESET = 24'd0;
	localparam logic [7:0]  LEVEL_SCALE_RESET   = 8'd51;
	localparam logic [15:0] PULSE_TICKS_RESET   = 16'd48;

	typedef struct packed {
		logic       repeating_mode;
		logic       length_reset_level;
		logic       hard_reset_level;
		logic       clock_level;
		logic       clock_connected;
		logic       step_back_level;
		logic       step_forward_level;
		logic       count_up_level;
		logic       count_clear_level;
		logic       count_clear_connected;
		logic [2:0] compare_gate_bits;
		logic [2:0] compare_gate_connected;
	} item_t;

	typedef struct packed {
		logic [2:0] active_stage;
		logic [7:0] stage_gates;
		logic [7:0] scaled_level;
		logic [3:0] repeat_count;
		logic [2:0] repeat_bits;
		logic [3:0] counter_value;
		logic       comparator_gate;
		logic       running_flag;
	} result_t;

endpackage

// ===== rtl/core/rss_seq.sv =====
`timescale 1ns / 1ps

// Stage sequencer: gate edge detection, stage index and run flag, plus the
// level and repeat lookup for the stage that results from this tick.
module rss_seq
	import rss_pkg::*;
#(
	parameter int unsigned STAGE_COUNT = 8,
	parameter int unsigned LEVEL_BITS  = 8,
	parameter int unsigned STAGE_BITS  = $clog2(STAGE_COUNT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  item_t                 item,
	input  logic                  pulse_fb,
	input  logic [63:0]           stage_levels,
	input  logic [23:0]           stage_repeats,
	input  logic [7:0]            level_scale,
	output logic [STAGE_BITS-1:0] stage_next,
	output logic                  run_next,
	output logic [7:0]            level_next,
	output logic [REP_BITS-1:0]   rep_next
);

	localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(STAGE_COUNT - 1);
	localparam logic [STAGE_BITS-1:0] FIRST_STAGE = '0;

	// Previous level bits: clock, back, forward, length reset, hard reset.
	localparam int unsigned P_CLK = 0;
	localparam int unsigned P_BACK = 1;
	localparam int unsigned P_FWD = 2;
	localparam int unsigned P_LEN = 3;
	localparam int unsigned P_HARD = 4;

	logic [STAGE_BITS-1:0] stage_q;
	logic                  run_q;
	logic                  mode_q;
	logic [4:0]            prev_q;
	logic [4:0]            now_lv;

	always_comb begin
		logic [STAGE_BITS-1:0] stg;
		logic                  run;
		logic [4:0]            rise;
		logic [63:0]           lvl_word;
		logic [23:0]           rep_word;
		logic [LEVEL_BITS-1:0] lvl;
		logic [LEVEL_BITS+7:0] prod;

		now_lv[P_CLK]  = item.clock_connected ? item.clock_level : pulse_fb;
		now_lv[P_BACK] = item.step_back_level;
		now_lv[P_FWD]  = item.step_forward_level;
		now_lv[P_LEN]  = item.length_reset_level;
		now_lv[P_HARD] = item.hard_reset_level;
		rise = now_lv & ~prev_q;

		stg = stage_q;
		run = run_q;
		if (!mode_q && item.repeating_mode) begin
			run = 1'b1;
		end
		if (rise[P_LEN]) begin
			stg = FIRST_STAGE;
			run = item.repeating_mode;
		end
		if (rise[P_HARD]) begin
			stg = FIRST_STAGE;
			run = 1'b1;
		end
		if (rise[P_BACK]) begin
			stg = (stg == FIRST_STAGE) ? LAST_STAGE : stg - 1'b1;
		end
		if (rise[P_FWD]) begin
			stg = (stg == LAST_STAGE) ? FIRST_STAGE : stg + 1'b1;
		end
		if (run && rise[P_CLK]) begin
			stg = (stg == LAST_STAGE) ? FIRST_STAGE : stg + 1'b1;
			if (!item.repeating_mode && stg == FIRST_STAGE) begin
				run = 1'b0;
			end
		end

		// Fields past the register width shift in as zero.
		lvl_word = stage_levels >> (LEVEL_BITS * int'(stg));
		rep_word = stage_repeats >> (REP_BITS * int'(stg));
		lvl = lvl_word[LEVEL_BITS-1:0];
		prod = (LEVEL_BITS + 8)'(lvl) * (LEVEL_BITS + 8)'(level_scale);

		stage_next = stg;
		run_next = run;
		level_next = 8'(prod >> 8);
		rep_next = rep_word[REP_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
			run_q <= 1'b1;
			mode_q <= 1'b0;
			prev_q <= '1;
		end else if (step) begin
			stage_q <= stage_next;
			run_q <= run_next;
			mode_q <= item.repeating_mode;
			prev_q <= now_lv;
		end
	end

endmodule

// ===== rtl/core/rss_cmp.sv =====
`timescale 1ns / 1ps

// Event counter, threshold compare and comparator pulse timer.
module rss_cmp
	import rss_pkg::*;
#(
	parameter int unsigned COUNT_LIMIT = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  item_t               item,
	input  logic [REP_BITS-1:0] rep,
	input  logic [15:0]         pulse_ticks,
	output logic [3:0]          count_next,
	output logic                gate_next,
	output logic                pulse_q
);

	localparam logic [3:0] LIMIT = 4'(COUNT_LIMIT);

	// Previous level bits: count up, count clear.
	localparam int unsigned P_UP = 0;
	localparam int unsigned P_CLR = 1;

	logic [3:0]  count_q;
	logic [15:0] remain_q;
	logic [15:0] remain_next;
	logic [1:0]  prev_q;
	logic [1:0]  now_lv;

	always_comb begin
		logic [1:0]          rise;
		logic [3:0]          cnt;
		logic [15:0]         rem;
		logic [REP_BITS-1:0] thr;

		now_lv[P_UP]  = item.count_up_level;
		now_lv[P_CLR] = item.count_clear_level;
		rise = now_lv & ~prev_q;

		cnt = count_q;
		if (rise[P_CLR]) begin
			cnt = '0;
		end
		if (rise[P_UP]) begin
			cnt = (cnt < LIMIT) ? cnt + 4'd1 : LIMIT;
		end

		// Unpatched comparator gates fall back to the stage's repeat bits.
		thr = (item.compare_gate_bits & item.compare_gate_connected)
			| (rep & ~item.compare_gate_connected);

		rem = remain_q;
		if (cnt > 4'(thr)) begin
			if (pulse_ticks > rem) begin
				rem = pulse_ticks;
			end
			if (!item.count_clear_connected) begin
				cnt = '0;
			end
		end

		gate_next = (rem != 16'd0);
		if (gate_next) begin
			rem = rem - 16'd1;
		end
		remain_next = rem;
		count_next = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			remain_q <= '0;
			prev_q <= '1;
			pulse_q <= 1'b0;
		end else if (step) begin
			count_q <= count_next;
			remain_q <= remain_next;
			prev_q <= now_lv;
			pulse_q <= gate_next;
		end
	end

endmodule

// ===== rtl/core/repeat_step_sequencer.sv =====
`timescale 1ns / 1ps

// Repeating step sequencer with gate counter and comparator pulse.
//
// Channels: item_valid/item_ready/item carries one sample tick of gate levels;
// result_valid/result_ready/result returns one result per tick, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the four configuration
// registers (levels, repeats, scale, pulse length); cfg_ready is always high.
// Writes must be made only while no transaction is in flight; not enforced.
//
// Flow: an accepted tick is registered into the input stage; its result is
// registered into the result register once that register is free or being
// taken. Throughput: one tick per cycle while the result register is free or
// draining, set by the single pass of edge detection, stage update, level
// multiply and counter compare between the two registers.
//
// Reset: stage 0, running, counter and pulse cleared, previous gate levels
// high so that gates held high at reset give no edge; configuration returns
// to its defaults. A stalled receiver holds the result; one more tick is
// taken into the input stage, then item_ready drops until the result leaves.
module repeat_step_sequencer
	import rss_pkg::*;
#(
	parameter int unsigned STAGE_COUNT = 8,
	parameter int unsigned COUNT_LIMIT = 10,
	parameter int unsigned LEVEL_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned STAGE_BITS = $clog2(STAGE_COUNT);

	logic [63:0] stage_levels_q;
	logic [23:0] stage_repeats_q;
	logic [7:0]  level_scale_q;
	logic [15:0] pulse_ticks_q;

	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	logic [STAGE_BITS-1:0] stage_next;
	logic                  run_next;
	logic [7:0]            level_next;
	logic [REP_BITS-1:0]   rep_next;
	logic [3:0]            count_next;
	logic                  gate_next;
	logic                  pulse_fb;

	// Process the held tick whenever the result register is free or draining.
	assign advance = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_levels_q <= STAGE_LEVELS_RESET;
			stage_repeats_q <= STAGE_REPEATS_RESET;
			level_scale_q <= LEVEL_SCALE_RESET;
			pulse_ticks_q <= PULSE_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STAGE_LEVELS: begin
					stage_levels_q <= cfg_data;
				end
				CFG_STAGE_REPEATS: begin
					stage_repeats_q <= cfg_data[23:0];
				end
				CFG_LEVEL_SCALE: begin
					level_scale_q <= cfg_data[7:0];
				end
				CFG_PULSE_TICKS: begin
					pulse_ticks_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input stage: hold the accepted transaction until it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	rss_seq #(
		.STAGE_COUNT (STAGE_COUNT),
		.LEVEL_BITS  (LEVEL_BITS),
		.STAGE_BITS  (STAGE_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.pulse_fb      (pulse_fb),
		.stage_levels  (stage_levels_q),
		.stage_repeats (stage_repeats_q),
		.level_scale   (level_scale_q),
		.stage_next    (stage_next),
		.run_next      (run_next),
		.level_next    (level_next),
		.rep_next      (rep_next)
	);

	rss_cmp #(
		.COUNT_LIMIT (COUNT_LIMIT)
	) u_cmp (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.rep         (rep_next),
		.pulse_ticks (pulse_ticks_q),
		.count_next  (count_next),
		.gate_next   (gate_next),
		.pulse_q     (pulse_fb)
	);

	// Result register: load on advance, drop valid once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.active_stage <= 3'(stage_next);
			result.stage_gates <= (int'(stage_next) < 8) ? (8'd1 << stage_next) : 8'd0;
			result.scaled_level <= level_next;
			result.repeat_count <= 4'(rep_next) + 4'd1;
			result.repeat_bits <= rep_next;
			result.counter_value <= count_next;
			result.comparator_gate <= gate_next;
			result.running_flag <= run_next;
		end
	end

	// A free result register never stalls the input side.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item_ready low while result register free");

	// The stage gate vector carries at most one active stage.
	a_gates_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0(result.stage_gates))
		else $error("stage_gates not one-hot");

	// The counter saturates at its limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.counter_value <= 4'(COUNT_LIMIT)))
		else $error("counter_value beyond limit");

	// A processed tick always lands in the result register.
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("result lost after advance");

endmodule

// ===== verif/repeat_step_sequencer_tb.sv =====
`timescale 1ns / 1ps

module repeat_step_sequencer_tb;
	import rss_pkg::*;

	localparam int unsigned DIRECTED_ROWS = 24;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PHASE_TICKS   = 225;
	localparam int unsigned HIT_CEILING   = 10;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	// One row of the directed plan: the tick to send and, where it is obvious,
	// the result typed in by hand instead of taken from the predictor.
	typedef struct packed {
		item_t   stim;
		logic    pinned;
		result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = CFG_STAGE_LEVELS;
	logic [63:0] cfg_data = '0;

	// Hand-typed expectation travelling alongside the tick on the input channel.
	logic        pin_flag = 1'b0;
	result_t     pin_want = '0;

	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// Sequencer state as the predictor sees it, starting from its reset values.
	logic [2:0]  seq_stage = 3'd0;
	logic        seq_running = 1'b1;
	logic        mode_seen = 1'b0;
	logic [3:0]  hit_count = 4'd0;
	logic [15:0] pulse_left = 16'd0;
	logic [6:0]  gate_history = 7'h7F;
	logic        pulse_was_high = 1'b0;

	// Shadow of the configuration registers.
	logic [63:0] levels_reg = STAGE_LEVELS_RESET;
	logic [23:0] repeats_reg = STAGE_REPEATS_RESET;
	logic [7:0]  scale_reg = LEVEL_SCALE_RESET;
	logic [15:0] ticks_reg = PULSE_TICKS_RESET;

	result_t     pending_results[$];
	plan_row_t   directed[DIRECTED_ROWS];
	result_t     predicted;
	result_t     oldest;

	repeat_step_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Advance the predicted sequencer by one sample tick and return its outputs.
	function automatic result_t sequencer_tick(item_t it);
		logic [6:0]  levels_now;
		logic [6:0]  rises;
		logic [2:0]  rep;
		logic [2:0]  threshold;
		logic [15:0] product;
		result_t     r;
		// Switching into repeating mode re-arms the clocked advance.
		if (!mode_seen && it.repeating_mode)
			seq_running = 1'b1;
		mode_seen = it.repeating_mode;
		// Without an external clock the previous tick's pulse clocks the sequencer.
		levels_now = {it.count_clear_level, it.count_up_level, it.hard_reset_level,
			it.length_reset_level, it.step_forward_level, it.step_back_level,
			it.clock_connected ? it.clock_level : pulse_was_high};
		rises = levels_now & ~gate_history;
		gate_history = levels_now;
		if (rises[3]) begin
			seq_stage = 3'd0;
			seq_running = it.repeating_mode;
		end
		if (rises[4]) begin
			seq_running = 1'b1;
			seq_stage = 3'd0;
		end
		if (rises[1])
			seq_stage = seq_stage - 3'd1;
		if (rises[2])
			seq_stage = seq_stage + 3'd1;
		// One-shot mode stops once the stage wraps back to the start.
		if (seq_running && rises[0]) begin
			seq_stage = seq_stage + 3'd1;
			if (!it.repeating_mode && seq_stage == 3'd0)
				seq_running = 1'b0;
		end
		product = 16'(levels_reg[8 * seq_stage +: 8]) * 16'(scale_reg);
		rep = repeats_reg[3 * seq_stage +: 3];
		if (rises[6])
			hit_count = 4'd0;
		if (rises[5] && hit_count < HIT_CEILING)
			hit_count = hit_count + 4'd1;
		// Patched comparator gates override the stage's repeat bits.
		threshold = (it.compare_gate_bits & it.compare_gate_connected)
			| (rep & ~it.compare_gate_connected);
		if (hit_count > threshold) begin
			// Retrigger only lengthens a running pulse, never shortens it.
			if (ticks_reg > pulse_left)
				pulse_left = ticks_reg;
			if (!it.count_clear_connected)
				hit_count = 4'd0;
		end
		r.comparator_gate = (pulse_left != 16'd0);
		if (pulse_left != 16'd0)
			pulse_left = pulse_left - 16'd1;
		pulse_was_high = r.comparator_gate;
		r.active_stage = seq_stage;
		r.stage_gates = 8'h01 << seq_stage;
		r.scaled_level = product[15:8];
		r.repeat_count = {1'b0, rep} + 4'd1;
		r.repeat_bits = rep;
		r.counter_value = hit_count;
		r.running_flag = seq_running;
		return r;
	endfunction

	function automatic item_t tick(logic mode, logic len_rst, logic hard_rst, logic clk_lvl,
			logic clk_conn, logic back, logic fwd, logic up, logic clr, logic clr_conn,
			logic [2:0] gbits, logic [2:0] gconn);
		return '{mode, len_rst, hard_rst, clk_lvl, clk_conn, back, fwd, up, clr, clr_conn,
			gbits, gconn};
	endfunction

	// Result under the reset configuration: every level reads 0, every repeat field 0.
	function automatic result_t at_reset_cfg(logic [2:0] stage, logic [3:0] count,
			logic gate, logic running);
		return '{stage, 8'h01 << stage, 8'd0, 4'd1, 3'd0, count, gate, running};
	endfunction

	// Drift the gate levels: clocks and counting gates move often, resets and
	// patching rarely, so that long runs of well-formed sequencing occur.
	function automatic item_t wander(item_t cur);
		item_t nx;
		nx = cur;
		if ($urandom_range(99) < 3)  nx.repeating_mode = ~cur.repeating_mode;
		if ($urandom_range(99) < 4)  nx.length_reset_level = ~cur.length_reset_level;
		if ($urandom_range(99) < 3)  nx.hard_reset_level = ~cur.hard_reset_level;
		if ($urandom_range(99) < 40) nx.clock_level = ~cur.clock_level;
		if ($urandom_range(99) < 3)  nx.clock_connected = ~cur.clock_connected;
		if ($urandom_range(99) < 12) nx.step_back_level = ~cur.step_back_level;
		if ($urandom_range(99) < 12) nx.step_forward_level = ~cur.step_forward_level;
		if ($urandom_range(99) < 45) nx.count_up_level = ~cur.count_up_level;
		if ($urandom_range(99) < 6)  nx.count_clear_level = ~cur.count_clear_level;
		if ($urandom_range(99) < 4)  nx.count_clear_connected = ~cur.count_clear_connected;
		if ($urandom_range(99) < 25) nx.compare_gate_bits = 3'($urandom_range(7));
		if ($urandom_range(99) < 5)  nx.compare_gate_connected = 3'($urandom_range(7));
		return nx;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Offer one tick after an optional idle gap; hold it until it is taken.
	task automatic send_tick(item_t it, logic pin, result_t want);
		while ($urandom_range(99) < tx_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		pin_flag <= pin;
		pin_want <= want;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers back to back; call only while the block is idle.
	task automatic load_config(logic [63:0] levels, logic [23:0] repeats, logic [7:0] scale,
			logic [15:0] ticks);
		cfg_index_t  idx[4];
		logic [63:0] val[4];
		int          i;
		idx = '{CFG_STAGE_LEVELS, CFG_STAGE_REPEATS, CFG_LEVEL_SCALE, CFG_PULSE_TICKS};
		val = '{levels, 64'(repeats), 64'(scale), 64'(ticks)};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		levels_reg = levels;
		repeats_reg = repeats;
		scale_reg = scale;
		ticks_reg = ticks;
	endtask

	// Receiver: stall at the rate the current phase asks for.
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= rx_stall_pct);

	// Scoreboard: predict on every accepted tick, check every accepted result
	// against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				predicted = sequencer_tick(item);
				pending_results.push_back(pin_flag ? pin_want : predicted);
			end
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no tick outstanding, got %h", $time, result);
				end else begin
					oldest = pending_results.pop_front();
					check_field("active_stage", oldest.active_stage, result.active_stage);
					check_field("stage_gates", oldest.stage_gates, result.stage_gates);
					check_field("scaled_level", oldest.scaled_level, result.scaled_level);
					check_field("repeat_count", oldest.repeat_count, result.repeat_count);
					check_field("repeat_bits", oldest.repeat_bits, result.repeat_bits);
					check_field("counter_value", oldest.counter_value, result.counter_value);
					check_field("comparator_gate", oldest.comparator_gate,
						result.comparator_gate);
					check_field("running_flag", oldest.running_flag, result.running_flag);
				end
			end
		end
	end

	// Watchdog: give up well beyond the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				pending_results.size());
			$display("repeat_step_sequencer_tb: FAIL");
			$finish;
		end
	end

	initial begin
		item_t       drift;
		logic [63:0] levels;
		logic [23:0] repeats;
		logic [7:0]  scale;
		logic [15:0] ticks;
		int          row;
		int          ph;
		int          n;

		// Directed plan, all under the reset configuration.
		// Gates already high at reset must give no edge.
		directed[0]  = '{tick(0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 7), 1'b1, at_reset_cfg(0, 0, 0, 1)};
		directed[1]  = '{tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(0, 0, 0, 1)};
		// Step forward, then back, then back across the wrap to the last stage.
		directed[2]  = '{tick(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(1, 0, 0, 1)};
		directed[3]  = '{tick(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(0, 0, 0, 1)};
		directed[4]  = '{tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[5]  = '{tick(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(7, 0, 0, 1)};
		// Count below the threshold, then drop the threshold to fire the pulse
		// with the counter cleared automatically.
		directed[6]  = '{tick(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 7, 7), 1'b1, at_reset_cfg(7, 1, 0, 1)};
		directed[7]  = '{tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7), 1'b1, at_reset_cfg(7, 0, 1, 1)};
		// Pulse feedback clocks the sequencer into stage 0, which stops one-shot mode.
		directed[8]  = '{tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(0, 0, 1, 0)};
		// Re-arm via repeating mode, then length reset in both modes.
		directed[9]  = '{tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[10] = '{tick(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[11] = '{tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[12] = '{tick(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, at_reset_cfg(0, 0, 1, 0)};
		// Hard reset re-arms; external clock advances.
		directed[13] = '{tick(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[14] = '{tick(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[15] = '{tick(0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		// Counter reset patched: no auto clear, retrigger, mixed gate mask, clear.
		directed[16] = '{tick(0, 0, 0, 1, 1, 0, 0, 1, 0, 1, 0, 7), 1'b0, '0};
		directed[17] = '{tick(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 2, 5), 1'b0, '0};
		directed[18] = '{tick(0, 0, 0, 0, 1, 0, 0, 0, 1, 1, 0, 0), 1'b0, '0};
		directed[19] = '{tick(0, 0, 0, 0, 1, 0, 0, 1, 1, 1, 2, 2), 1'b0, '0};
		// Both step buttons and the clock on one tick, then every gate at once.
		directed[20] = '{tick(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[21] = '{tick(0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0};
		directed[22] = '{tick(1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 7, 7), 1'b0, '0};
		directed[23] = '{tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};

		// Hold reset, release it at an edge, never assert it again.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++)
			send_tick(directed[row].stim, directed[row].pinned, directed[row].want);
		settle();

		drift = directed[DIRECTED_ROWS - 1].stim;
		for (ph = 0; ph < PHASES; ph++) begin
			// Extremes first, a pulse that outlasts the run only in the last phase.
			case (ph)
				0: begin
					levels = '1;
					repeats = '1;
					scale = 8'hFF;
					ticks = 16'd1;
				end
				1: begin
					levels = '0;
					repeats = '0;
					scale = 8'h00;
					ticks = 16'd0;
				end
				PHASES - 1: begin
					levels = {$urandom, $urandom};
					repeats = 24'($urandom);
					scale = 8'($urandom);
					ticks = 16'hFFFF;
				end
				default: begin
					levels = {$urandom, $urandom};
					repeats = 24'($urandom);
					scale = 8'($urandom);
					ticks = 16'($urandom_range(1, 6));
				end
			endcase
			load_config(levels, repeats, scale, ticks);

			// Cycle through the idling patterns, one per phase.
			case (ph % 4)
				0: begin
					tx_gap_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_gap_pct = 48;
					rx_stall_pct = 0;
				end
				2: begin
					tx_gap_pct = 0;
					rx_stall_pct = 48;
				end
				default: begin
					tx_gap_pct = 12;
					rx_stall_pct = 12;
				end
			endcase

			for (n = 0; n < PHASE_TICKS; n++) begin
				// Mid-phase, let the pipeline run completely dry once.
				if (n == PHASE_TICKS / 2)
					settle();
				drift = wander(drift);
				send_tick(drift, 1'b0, '0);
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("repeat_step_sequencer_tb: PASS");
		else
			$display("repeat_step_sequencer_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rss_pkg.sv
rtl/core/rss_seq.sv
rtl/core/rss_cmp.sv
rtl/core/repeat_step_sequencer.sv
verif/repeat_step_sequencer_tb.sv
